[rtl/avsc_pkg.sv]
// Shared types, widths and operation codes of the address-space view classifier.
package avsc_pkg;

  // Default number of table entries; the top level exposes it as a parameter.
  localparam int TableEntriesDefault = 16;

  // Fixed field widths.
  localparam int OpW    = 3;
  localparam int RootW  = 64;
  localparam int SlotW  = 5;
  localparam int CountW = 5;
  localparam int StatW  = 32;
  localparam int CfgIdxW = 1;

  // Operation codes.
  localparam logic [OpW-1:0] OP_LOOKUP         = 3'd0;
  localparam logic [OpW-1:0] OP_REGISTER       = 3'd1;
  localparam logic [OpW-1:0] OP_UNREGISTER     = 3'd2;
  localparam logic [OpW-1:0] OP_CLEAR          = 3'd3;
  localparam logic [OpW-1:0] OP_RESET_COUNTERS = 3'd4;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_TARGET_ROOT   = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_TARGET_ENABLE = 1'b1;

  // Token that travels down the row of cells, one cell per cycle while the row advances.
  typedef struct packed {
    logic              valid;
    logic [OpW-1:0]    op;
    logic [RootW-1:0]  key;
    logic              hit;     // a valid entry matched the key (before any change)
    logic              taken;   // a register operation has claimed a slot
    logic [SlotW-1:0]  slot;    // 1-based slot claimed, or zero
    logic [CountW-1:0] count;   // running count of valid entries after the operation
  } token_t;

endpackage

[rtl/address_space_view_classifier_unit.sv]
// Top level of the address-space view classifier: cell row, result stage and config registers.
//
// The table is a row of TABLE_ENTRIES cells, one root per cell. Each transaction travels
// down the row one cell per cycle while the row is not stalled and then through one result
// stage, where its result is registered. Transactions follow each other one per cycle while
// the row is not stalled, because every cell sees them in order and updates its entry before
// the next one arrives. The whole row stalls while a result waits on the output, so in_ready
// follows out_ready whenever the result register is full.
// Configuration writes are always accepted and should be made only while no transaction is
// in flight.
module address_space_view_classifier_unit import avsc_pkg::*; #(
  parameter int TABLE_ENTRIES = TableEntriesDefault
) (
  input  logic               clk,
  input  logic               rst,
  // Input channel.
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OpW-1:0]     operation,
  input  logic [RootW-1:0]   root_value,
  // Output channel.
  output logic               out_valid,
  input  logic               out_ready,
  output logic               view,
  output logic [SlotW-1:0]   slot_number,
  output logic               entry_match,
  output logic [CountW-1:0]  occupied_count,
  output logic [StatW-1:0]   target_hits,
  output logic [StatW-1:0]   table_hits,
  output logic [StatW-1:0]   other_hits,
  // Configuration channel.
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [RootW-1:0]   cfg_data
);

  logic             advance;
  logic [RootW-1:0] target_root;
  logic             target_enable;
  token_t           chain_tok [TABLE_ENTRIES+1];

  // The row moves whenever the result register is empty or being emptied.
  assign advance   = !out_valid || out_ready;
  assign in_ready  = advance;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_root   <= '0;
      target_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TARGET_ROOT:   target_root   <= cfg_data;
        CFG_TARGET_ENABLE: target_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Token entering the first cell.
  always_comb begin
    chain_tok[0].valid = in_valid && in_ready;
    chain_tok[0].op    = operation;
    chain_tok[0].key   = root_value;
    chain_tok[0].hit   = 1'b0;
    chain_tok[0].taken = 1'b0;
    chain_tok[0].slot  = '0;
    chain_tok[0].count = '0;
  end

  // Row of table cells.
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    avsc_cell #(
      .INDEX(g)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .advance(advance),
      .tok_in (chain_tok[g]),
      .tok_out(chain_tok[g+1])
    );
  end

  // Lookup decision, counters and result register.
  avsc_result u_result (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .tok_in        (chain_tok[TABLE_ENTRIES]),
    .target_root   (target_root),
    .target_enable (target_enable),
    .out_valid     (out_valid),
    .view          (view),
    .slot_number   (slot_number),
    .entry_match   (entry_match),
    .occupied_count(occupied_count),
    .target_hits   (target_hits),
    .table_hits    (table_hits),
    .other_hits    (other_hits)
  );

`ifndef NO_ASSERTIONS
  // An accepted transaction is in the first cell on the next cycle.
  a_enter_row: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> chain_tok[1].valid)
    else $error("accepted transaction did not enter the cell row");

  // A stalled row holds its first token.
  a_row_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(chain_tok[1]))
    else $error("cell row moved while the result was stalled");

  // A hooked view comes only from a lookup, which never claims a slot.
  a_hooked_no_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && view |-> slot_number == '0)
    else $error("hooked view reported together with a slot number");
`endif

endmodule

[rtl/avsc_cell.sv]
// One table entry of the classifier row: holds a root, updates it and forwards the token.
module avsc_cell import avsc_pkg::*; #(
  parameter int INDEX = 0
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   advance,
  input  token_t tok_in,
  output token_t tok_out
);

  localparam logic [SlotW-1:0] SlotId = SlotW'(INDEX + 1);

  logic             ent_valid;
  logic [RootW-1:0] ent_root;

  logic   match;
  logic   take;
  logic   release_ent;
  logic   valid_after;
  token_t tok_next;

  // Compare against the stored root and decide what this entry does.
  always_comb begin
    match       = tok_in.valid && ent_valid && (ent_root == tok_in.key);
    take        = tok_in.valid && (tok_in.op == OP_REGISTER) && !tok_in.taken && !ent_valid;
    release_ent = tok_in.valid &&
                  (((tok_in.op == OP_UNREGISTER) && match && !tok_in.hit) ||
                   (tok_in.op == OP_CLEAR));
    if (take) begin
      valid_after = 1'b1;
    end else if (release_ent) begin
      valid_after = 1'b0;
    end else begin
      valid_after = ent_valid;
    end

    tok_next       = tok_in;
    tok_next.hit   = tok_in.hit | match;
    tok_next.taken = tok_in.taken | take;
    tok_next.slot  = take ? SlotId : tok_in.slot;
    tok_next.count = tok_in.count + CountW'(valid_after);
  end

  // Entry storage and the token register toward the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid     <= 1'b0;
      tok_out.valid <= 1'b0;
    end else if (advance) begin
      tok_out   <= tok_next;
      ent_valid <= valid_after;
    end
    if (advance && take) begin
      ent_root <= tok_in.key;
    end
  end

endmodule

[rtl/avsc_result.sv]
// Final stage of the classifier: lookup decision, statistics counters and result register.
module avsc_result import avsc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  token_t             tok_in,
  input  logic [RootW-1:0]   target_root,
  input  logic               target_enable,
  output logic               out_valid,
  output logic               view,
  output logic [SlotW-1:0]   slot_number,
  output logic               entry_match,
  output logic [CountW-1:0]  occupied_count,
  output logic [StatW-1:0]   target_hits,
  output logic [StatW-1:0]   table_hits,
  output logic [StatW-1:0]   other_hits
);

  logic             view_next;
  logic [StatW-1:0] target_hits_next;
  logic [StatW-1:0] table_hits_next;
  logic [StatW-1:0] other_hits_next;

  // Classify a lookup and work out the counters after the operation.
  always_comb begin
    view_next        = 1'b0;
    target_hits_next = target_hits;
    table_hits_next  = table_hits;
    other_hits_next  = other_hits;
    case (tok_in.op)
      OP_LOOKUP: begin
        if (!target_enable) begin
          other_hits_next = other_hits + StatW'(1);
        end else if (tok_in.key == target_root) begin
          view_next        = 1'b1;
          target_hits_next = target_hits + StatW'(1);
        end else if (tok_in.hit) begin
          table_hits_next = table_hits + StatW'(1);
        end else begin
          other_hits_next = other_hits + StatW'(1);
        end
      end
      OP_RESET_COUNTERS: begin
        target_hits_next = '0;
        table_hits_next  = '0;
        other_hits_next  = '0;
      end
      default: begin
      end
    endcase
  end

  // Result register; the counters change only when a new result is loaded.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      target_hits <= '0;
      table_hits  <= '0;
      other_hits  <= '0;
    end else if (advance) begin
      out_valid <= tok_in.valid;
      if (tok_in.valid) begin
        target_hits <= target_hits_next;
        table_hits  <= table_hits_next;
        other_hits  <= other_hits_next;
      end
    end
    if (advance && tok_in.valid) begin
      view           <= view_next;
      slot_number    <= tok_in.slot;
      entry_match    <= tok_in.hit;
      occupied_count <= tok_in.count;
    end
  end

endmodule

[sim/avsc_checker.sv]
// Checker for the address-space view classifier: predicts every result and compares it.
module avsc_checker import avsc_pkg::*; #(
  parameter int TABLE_ENTRIES = TableEntriesDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [OpW-1:0]     operation,
  input  logic [RootW-1:0]   root_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               view,
  input  logic [SlotW-1:0]   slot_number,
  input  logic               entry_match,
  input  logic [CountW-1:0]  occupied_count,
  input  logic [StatW-1:0]   target_hits,
  input  logic [StatW-1:0]   table_hits,
  input  logic [StatW-1:0]   other_hits,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [RootW-1:0]   cfg_data,
  output int                 failures,
  output int                 in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ReportLimit = 10;

  // One predicted result transaction.
  typedef struct packed {
    logic              view;
    logic [SlotW-1:0]  slot_number;
    logic              entry_match;
    logic [CountW-1:0] occupied;
    logic [StatW-1:0]  target_hits;
    logic [StatW-1:0]  table_hits;
    logic [StatW-1:0]  other_hits;
  } view_result_t;

  // Shadow copy of the root table, the counters and the target registers.
  logic             root_valid [TABLE_ENTRIES];
  logic [RootW-1:0] root_entry [TABLE_ENTRIES];
  logic [StatW-1:0] target_tally;
  logic [StatW-1:0] table_tally;
  logic [StatW-1:0] other_tally;
  logic [RootW-1:0] target_root_q;
  logic             target_active;

  view_result_t expected_views[$];
  int           error_total = 0;

  assign failures = error_total;

  // Apply one operation to the shadow state and return the result it must produce.
  function automatic view_result_t classify_root(input logic [OpW-1:0] op,
                                                 input logic [RootW-1:0] key);
    view_result_t res;
    int           hit_slot;
    int           free_slot;
    int           used;
    res       = '0;
    hit_slot  = -1;
    free_slot = -1;
    used      = 0;
    // The compare sees the table as it was before this operation.
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (root_valid[i] && root_entry[i] == key) hit_slot = i;
      if (!root_valid[i]) free_slot = i;
    end
    case (op)
      OP_LOOKUP: begin
        // Inactive target wins, then the target compare, then the table.
        if (!target_active) begin
          other_tally++;
        end else if (key == target_root_q) begin
          target_tally++;
          res.view = 1'b1;
        end else if (hit_slot >= 0) begin
          table_tally++;
        end else begin
          other_tally++;
        end
      end
      OP_REGISTER: begin
        if (free_slot >= 0) begin
          root_valid[free_slot] = 1'b1;
          root_entry[free_slot] = key;
          res.slot_number       = SlotW'(free_slot + 1);
        end
      end
      OP_UNREGISTER: begin
        if (hit_slot >= 0) begin
          root_valid[hit_slot] = 1'b0;
          root_entry[hit_slot] = '0;
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          root_valid[i] = 1'b0;
          root_entry[i] = '0;
        end
      end
      OP_RESET_COUNTERS: begin
        target_tally = '0;
        table_tally  = '0;
        other_tally  = '0;
      end
      default: ;
    endcase
    for (int i = 0; i < TABLE_ENTRIES; i++) used += int'(root_valid[i]);
    res.entry_match = (hit_slot >= 0);
    res.occupied    = CountW'(used);
    res.target_hits = target_tally;
    res.table_hits  = table_tally;
    res.other_hits  = other_tally;
    return res;
  endfunction

  // Count a failure and report it while under the report limit.
  task automatic note_failure(input string what, input logic [63:0] want,
                              input logic [63:0] got);
    error_total++;
    if (error_total <= ReportLimit) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $realtime, what, want, got);
    end
  endtask

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) note_failure(what, want, got);
  endtask

  // Watch all three channels; results are compared before new requests are predicted.
  always @(posedge clk) begin
    view_result_t want;
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        root_valid[i] = 1'b0;
        root_entry[i] = '0;
      end
      target_tally  = '0;
      table_tally   = '0;
      other_tally   = '0;
      target_root_q = '0;
      target_active = 1'b0;
      expected_views.delete();
    end else begin
      if ($isunknown({in_ready, out_valid, cfg_ready})) begin
        note_failure("handshake control", 64'd0, {61'd0, in_ready, out_valid, cfg_ready});
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TARGET_ROOT:   target_root_q = cfg_data;
          CFG_TARGET_ENABLE: target_active = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_views.size() == 0) begin
          note_failure("unexpected result transaction", 64'd0, 64'd1);
        end else begin
          want = expected_views.pop_front();
          check_field("view", 64'(want.view), 64'(view));
          check_field("slot_number", 64'(want.slot_number), 64'(slot_number));
          check_field("entry_match", 64'(want.entry_match), 64'(entry_match));
          check_field("occupied_count", 64'(want.occupied), 64'(occupied_count));
          check_field("target_hits", 64'(want.target_hits), 64'(target_hits));
          check_field("table_hits", 64'(want.table_hits), 64'(table_hits));
          check_field("other_hits", 64'(want.other_hits), 64'(other_hits));
        end
      end
      if (in_valid && in_ready) begin
        expected_views.push_back(classify_root(operation, root_value));
      end
    end
    in_flight <= expected_views.size();
  end

endmodule

[sim/tb_top.sv]
// Testbench top for the address-space view classifier: stimulus, back-pressure and verdict.
module tb_top import avsc_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TableEntries = TableEntriesDefault;
  localparam int PhaseCount   = 6;
  localparam int PhaseItems   = 250;
  localparam int IdlePercent  = 7;
  localparam int SteadyFrom   = 900;
  localparam int SteadyTo     = 1600;
  localparam int CycleLimit   = 200000;
  localparam int PoolSize     = 8;

  // Operation codes the block must ignore.
  localparam logic [OpW-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [OpW-1:0] OP_UNUSED_LAST  = 3'd7;

  localparam logic [RootW-1:0] ROOT_ONES = '1;
  localparam logic [RootW-1:0] ROOT_FILL = 64'hA5A5_5A5A_C3C3_3C3C;

  logic               clk;
  logic               rst            = 1'b1;
  logic               in_valid       = 1'b0;
  logic               in_ready;
  logic [OpW-1:0]     operation      = '0;
  logic [RootW-1:0]   root_value     = '0;
  logic               out_valid;
  logic               out_ready      = 1'b0;
  logic               view;
  logic [SlotW-1:0]   slot_number;
  logic               entry_match;
  logic [CountW-1:0]  occupied_count;
  logic [StatW-1:0]   target_hits;
  logic [StatW-1:0]   table_hits;
  logic [StatW-1:0]   other_hits;
  logic               cfg_valid      = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index      = '0;
  logic [RootW-1:0]   cfg_data       = '0;
  int                 failures;
  int                 in_flight;

  int unsigned        cycle_count    = 0;
  logic               steady;
  logic [RootW-1:0]   root_pool [PoolSize];

  address_space_view_classifier_unit #(.TABLE_ENTRIES(TableEntries)) u_top (.*);

  avsc_checker #(.TABLE_ENTRIES(TableEntries)) u_checker (.*);

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // A window of the run with no idling on either side.
  assign steady = (cycle_count >= SteadyFrom) && (cycle_count < SteadyTo);

  // Result side: random stalls outside the steady window.
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= IdlePercent);
  end

  // Watchdog.
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("tb_top failed");
    $finish;
  end

  // Present one request transaction, with a random idle gap ahead of it.
  task automatic send_request(input logic [OpW-1:0] op, input logic [RootW-1:0] root);
    while (!steady && $urandom_range(99) < IdlePercent) begin
      in_valid   <= 1'b0;
      operation  <= OpW'($urandom);
      root_value <= {$urandom, $urandom};
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    root_value <= root;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (in_flight != 0);
  endtask

  // Write both target registers once every result in flight has come back.
  task automatic configure(input logic [RootW-1:0] root, input logic enable);
    logic [RootW-1:0] noise;
    noise    = {$urandom, $urandom};
    in_valid <= 1'b0;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_TARGET_ROOT;
    cfg_data  <= root;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_TARGET_ENABLE;
    cfg_data  <= {noise[RootW-1:1], enable};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [OpW-1:0] pick_operation(input bit fill_heavy);
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return OP_LOOKUP;
    if (roll < (fill_heavy ? 75 : 60)) return OP_REGISTER;
    if (roll < 90) return OP_UNREGISTER;
    if (roll < 91) return OP_CLEAR;
    if (roll < 94) return OP_RESET_COUNTERS;
    return OpW'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
  endfunction

  // Mostly roots from a small pool, so lookups and unregisters find matches.
  function automatic logic [RootW-1:0] pick_root(input logic [RootW-1:0] target);
    int roll;
    roll = $urandom_range(99);
    if (roll < 15) return {$urandom, $urandom};
    if (roll < 25) return target;
    return root_pool[$urandom_range(PoolSize - 1)];
  endfunction

  // Main stimulus sequence.
  initial begin
    logic [RootW-1:0] target;
    logic             enable;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Target inactive: a root equal to the target still gets the clean view.
    configure(ROOT_ONES, 1'b0);
    send_request(OP_LOOKUP, '0);
    send_request(OP_REGISTER, '0);
    send_request(OP_REGISTER, ROOT_ONES);
    send_request(OP_LOOKUP, ROOT_ONES);

    // Target active: hooked view even though the root is also in the table.
    configure(ROOT_ONES, 1'b1);
    send_request(OP_LOOKUP, ROOT_ONES);
    send_request(OP_LOOKUP, '0);
    send_request(OP_LOOKUP, 64'h0000_0000_0000_0005);
    send_request(OP_UNREGISTER, '0);
    send_request(OP_UNREGISTER, 64'h1234_5678_9ABC_DEF0);
    for (int code = OP_UNUSED_FIRST; code <= OP_UNUSED_LAST; code++) begin
      send_request(OpW'(code), ROOT_ONES);
    end
    send_request(OP_RESET_COUNTERS, {$urandom, $urandom});
    send_request(OP_CLEAR, {$urandom, $urandom});

    // Fill every slot with one root; the extra register finds the table full.
    repeat (TableEntries + 1) send_request(OP_REGISTER, ROOT_FILL);
    send_request(OP_LOOKUP, ROOT_FILL);

    // Random phases, each with a fresh root pool and target setting.
    for (int phase = 0; phase < PhaseCount; phase++) begin
      root_pool[0] = '0;
      root_pool[1] = ROOT_ONES;
      for (int k = 2; k < PoolSize; k++) root_pool[k] = {$urandom, $urandom};
      // Two roots one bit apart check that the compare uses every bit.
      root_pool[3] = root_pool[2] ^ (64'd1 << $urandom_range(RootW - 1));
      case (phase)
        0:       target = '0;
        1:       target = ROOT_ONES;
        default: target = $urandom_range(1) ? root_pool[$urandom_range(PoolSize - 1)]
                                            : {$urandom, $urandom};
      endcase
      enable = (phase == 2) ? 1'b0 : (phase < 4) ? 1'b1 : 1'($urandom_range(1));
      configure(target, enable);
      for (int n = 0; n < PhaseItems; n++) begin
        send_request(pick_operation(phase % 2 == 1), pick_root(target));
      end
    end

    // Let every result come back, then watch a little longer for strays.
    in_valid <= 1'b0;
    wait_drained();
    repeat (TableEntries + 4) @(posedge clk);
    if (failures == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
